// ===== design/dnd_pkg.sv =====
// Shared constants and types for the DNS name decompressor.
package dnd_pkg;

  localparam int PACKET_BYTES_DEF   = 4096;
  localparam int MAX_NAME_BYTES_DEF = 512;

  // Byte lanes in one result word
  localparam int WORD_BYTES = 8;

  // Width used for range checks on raw request fields
  localparam int CMP_W = 16;

  // Depth of the command queue between front and back
  localparam int Q_DEPTH = 2;

  // Top two bits of a length byte
  localparam logic [1:0] KIND_LABEL = 2'b00;
  localparam logic [1:0] KIND_PTR   = 2'b11;

  localparam logic [7:0] LEN_MASK = 8'h3f;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DROP,
    CMD_DECODE,
    CMD_BAD
  } cmd_kind_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_HEAD,
    W_LABEL,
    W_PTR,
    W_BAD,
    W_READ,
    W_PUSH
  } walk_state_t;

endpackage

// ===== design/dnd_req_if.sv =====
// Request channel: packet byte loads and name decode requests.
interface dnd_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] load_addr;
  logic [7:0]  load_byte;
  logic [11:0] start_offset;
  logic [12:0] packet_len;

  modport source (output valid, req_type, load_addr, load_byte, start_offset, packet_len,
                  input ready);
  modport sink   (input valid, req_type, load_addr, load_byte, start_offset, packet_len,
                  output ready);
endinterface

// ===== design/dnd_res_if.sv =====
// Result channel: decoded name words.
interface dnd_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] name_word;
  logic [3:0]  word_bytes;
  logic        last_word;
  logic        malformed;
  logic [12:0] end_offset;
  logic [9:0]  name_length;

  modport source (output valid, name_word, word_bytes, last_word, malformed, end_offset,
                  name_length, input ready);
  modport sink   (input valid, name_word, word_bytes, last_word, malformed, end_offset,
                  name_length, output ready);
endinterface

// ===== design/dnd_front.sv =====
// Request intake: classify each request and queue it for the walker; out-of-range loads are dropped.
module dnd_front #(
  parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  dnd_req_if.sink                             req,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output dnd_pkg::cmd_kind_t                  cmd_kind,
  output logic [$clog2(PACKET_BYTES)-1:0]     cmd_addr,
  output logic [7:0]                          cmd_byte,
  output logic [$clog2(PACKET_BYTES+1)-1:0]   cmd_plen
);
  import dnd_pkg::*;

  localparam int AW  = $clog2(PACKET_BYTES);
  localparam int PLW = $clog2(PACKET_BYTES + 1);
  localparam int QPW = $clog2(Q_DEPTH);
  localparam int QCW = $clog2(Q_DEPTH + 1);

  cmd_kind_t        q_kind [Q_DEPTH];
  logic [AW-1:0]    q_addr [Q_DEPTH];
  logic [7:0]       q_byte [Q_DEPTH];
  logic [PLW-1:0]   q_plen [Q_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  cmd_kind_t        in_kind;
  logic [PLW-1:0]   plen_sat;
  logic             addr_ok;
  logic             push;
  logic             pop;

  // Clamp packet length to the store size
  assign plen_sat = (CMP_W'(req.packet_len) > CMP_W'(PACKET_BYTES)) ?
                    PLW'(PACKET_BYTES) : PLW'(req.packet_len);
  assign addr_ok  = CMP_W'(req.load_addr) < CMP_W'(PACKET_BYTES);

  always_comb begin
    if (req.req_type) begin
      in_kind = (CMP_W'(req.start_offset) >= CMP_W'(plen_sat)) ? CMD_BAD : CMD_DECODE;
    end else begin
      in_kind = addr_ok ? CMD_LOAD : CMD_DROP;
    end
  end

  assign req.ready = count < QCW'(Q_DEPTH);
  // Drop out-of-range loads here; they never reach the queue
  assign push      = req.valid && req.ready && (in_kind != CMD_DROP);
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_kind[wr_ptr] <= in_kind;
      q_addr[wr_ptr] <= req.req_type ? AW'(req.start_offset) : AW'(req.load_addr);
      q_byte[wr_ptr] <= req.load_byte;
      q_plen[wr_ptr] <= plen_sat;
    end
  end

  assign cmd_valid = count != '0;
  assign cmd_kind  = q_kind[rd_ptr];
  assign cmd_addr  = q_addr[rd_ptr];
  assign cmd_byte  = q_byte[rd_ptr];
  assign cmd_plen  = q_plen[rd_ptr];

endmodule

// ===== design/dnd_namebuf.sv =====
// Name buffer: eight byte banks, written a byte at a time, read a word at a time.
module dnd_namebuf #(
  parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_NAME_BYTES)-1:0]   wr_idx,
  input  logic [7:0]                          wr_byte,
  input  logic [$clog2(MAX_NAME_BYTES)-4:0]   rd_word,
  output logic [63:0]                         rd_data
);
  import dnd_pkg::*;

  localparam int NIW    = $clog2(MAX_NAME_BYTES);
  localparam int NWORDS = (MAX_NAME_BYTES + WORD_BYTES - 1) / WORD_BYTES;

  for (genvar g = 0; g < WORD_BYTES; g++) begin : g_bank
    logic [7:0] bank [NWORDS];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_idx[2:0] == 3'(g))) begin
        bank[wr_idx[NIW-1:3]] <= wr_byte;
      end
      rd_data[8*g +: 8] <= bank[rd_word];
    end
  end

endmodule

// ===== design/dnd_walk.sv =====
// Walker: packet store, label and pointer walk, and result word output.
module dnd_walk #(
  parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
  parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  dnd_pkg::cmd_kind_t                  cmd_kind,
  input  logic [$clog2(PACKET_BYTES)-1:0]     cmd_addr,
  input  logic [7:0]                          cmd_byte,
  input  logic [$clog2(PACKET_BYTES+1)-1:0]   cmd_plen,
  dnd_res_if.source                           res
);
  import dnd_pkg::*;

  localparam int AW  = $clog2(PACKET_BYTES);
  localparam int PLW = $clog2(PACKET_BYTES + 1);
  localparam int XW  = PLW + 1;
  localparam int NLW = $clog2(MAX_NAME_BYTES + 1);
  localparam int NIW = $clog2(MAX_NAME_BYTES);
  localparam int NWW = NIW - 3;

  walk_state_t      state, state_next;
  logic [AW-1:0]    pos, pos_next;
  logic [AW-1:0]    endp, endp_next;
  logic [PLW-1:0]   plen, plen_next;
  logic [NLW-1:0]   nlen, nlen_next;
  logic [5:0]       rem, rem_next;
  logic [5:0]       hi6, hi6_next;
  logic             followed, followed_next;
  logic [NWW-1:0]   k, k_next;

  logic [7:0]       store [PACKET_BYTES];
  logic [7:0]       store_q;
  logic [AW-1:0]    rd_addr;
  logic             st_we;

  logic             nb_we;
  logic [7:0]       nb_byte;
  logic [63:0]      nb_q;

  logic             out_valid;
  logic [63:0]      out_word;
  logic [3:0]       out_bytes;
  logic             out_last;
  logic             out_malformed;
  logic [12:0]      out_end;
  logic [9:0]       out_len;
  logic             out_free;
  logic             load_bad;
  logic             load_word;

  logic [5:0]       len;
  logic [13:0]      tgt;
  logic             lab_over;
  logic             name_over;
  logic             ptr_over;
  logic [NLW-1:0]   remw;
  logic             word_last;
  logic [3:0]       word_cnt;
  logic [63:0]      word_masked;

  assign len       = store_q[5:0] & LEN_MASK[5:0];
  assign tgt       = {hi6, store_q};
  assign lab_over  = (XW'(pos) + XW'(len) + XW'(1)) >= XW'(plen);
  assign name_over = ((NLW+1)'(nlen) + (NLW+1)'(len) + (NLW+1)'(2)) >
                     (NLW+1)'(MAX_NAME_BYTES);
  assign ptr_over  = (XW'(pos) + XW'(1)) >= XW'(plen);

  assign remw      = nlen - NLW'({k, 3'b000});
  assign word_last = remw <= NLW'(WORD_BYTES);
  assign word_cnt  = word_last ? 4'(remw) : 4'(WORD_BYTES);

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      word_masked[8*i +: 8] = (4'(i) < word_cnt) ? nb_q[8*i +: 8] : 8'h00;
    end
  end

  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    endp     <= endp_next;
    plen     <= plen_next;
    nlen     <= nlen_next;
    rem      <= rem_next;
    hi6      <= hi6_next;
    followed <= followed_next;
    k        <= k_next;
  end

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    endp_next     = endp;
    plen_next     = plen;
    nlen_next     = nlen;
    rem_next      = rem;
    hi6_next      = hi6;
    followed_next = followed;
    k_next        = k;
    rd_addr       = pos;
    st_we         = 1'b0;
    nb_we         = 1'b0;
    nb_byte       = store_q;
    cmd_ready     = 1'b0;
    load_bad      = 1'b0;
    load_word     = 1'b0;

    unique case (state)
      W_IDLE: begin
        cmd_ready = 1'b1;
        rd_addr   = cmd_addr;
        if (cmd_valid) begin
          unique case (cmd_kind)
            CMD_LOAD: st_we = 1'b1;
            CMD_DECODE: begin
              pos_next      = cmd_addr;
              endp_next     = cmd_addr;
              plen_next     = cmd_plen;
              nlen_next     = '0;
              followed_next = 1'b0;
              k_next        = '0;
              state_next    = W_HEAD;
            end
            CMD_BAD: begin
              nlen_next  = '0;
              state_next = W_BAD;
            end
            CMD_DROP: state_next = W_IDLE;
            default:  state_next = W_IDLE;
          endcase
        end
      end

      W_HEAD: begin
        priority if (store_q == 8'h00) begin
          // Terminator: store it and start output
          nb_we      = 1'b1;
          nlen_next  = nlen + NLW'(1);
          state_next = W_READ;
        end else if (store_q[7:6] == KIND_PTR) begin
          if (ptr_over) begin
            state_next = W_BAD;
          end else begin
            rd_addr  = pos + AW'(1);
            hi6_next = store_q[5:0];
            if (!followed) begin
              endp_next     = pos + AW'(1);
              followed_next = 1'b1;
            end
            state_next = W_PTR;
          end
        end else if (store_q[7:6] == KIND_LABEL) begin
          if (lab_over || name_over) begin
            state_next = W_BAD;
          end else begin
            nb_we      = 1'b1;
            nlen_next  = nlen + NLW'(1);
            rem_next   = len;
            pos_next   = pos + AW'(1);
            rd_addr    = pos + AW'(1);
            state_next = W_LABEL;
          end
        end else begin
          state_next = W_BAD;
        end
      end

      W_LABEL: begin
        nb_we     = 1'b1;
        nlen_next = nlen + NLW'(1);
        rem_next  = rem - 6'd1;
        pos_next  = pos + AW'(1);
        rd_addr   = pos + AW'(1);
        if (rem == 6'd1) begin
          if (!followed) begin
            endp_next = pos + AW'(1);
          end
          state_next = W_HEAD;
        end
      end

      W_PTR: begin
        // Target must lie strictly before the pointer's first byte
        if (tgt >= 14'(pos)) begin
          state_next = W_BAD;
        end else begin
          pos_next   = AW'(tgt);
          rd_addr    = AW'(tgt);
          state_next = W_HEAD;
        end
      end

      W_BAD: begin
        if (out_free) begin
          load_bad   = 1'b1;
          state_next = W_IDLE;
        end
      end

      W_READ: state_next = W_PUSH;

      W_PUSH: begin
        if (out_free) begin
          load_word = 1'b1;
          if (word_last) begin
            state_next = W_IDLE;
          end else begin
            k_next     = k + NWW'(1);
            state_next = W_READ;
          end
        end
      end

      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[cmd_addr] <= cmd_byte;
    end
    store_q <= store[rd_addr];
  end

  dnd_namebuf #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_namebuf (
    .clk     (clk),
    .wr_en   (nb_we),
    .wr_idx  (NIW'(nlen)),
    .wr_byte (nb_byte),
    .rd_word (k),
    .rd_data (nb_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_bad || load_word) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_bad) begin
      out_word      <= '0;
      out_bytes     <= '0;
      out_last      <= 1'b1;
      out_malformed <= 1'b1;
      out_end       <= '0;
      out_len       <= '0;
    end else if (load_word) begin
      out_word      <= word_masked;
      out_bytes     <= word_cnt;
      out_last      <= word_last;
      out_malformed <= 1'b0;
      out_end       <= word_last ? 13'(XW'(endp) + XW'(1)) : '0;
      out_len       <= word_last ? 10'(nlen) : '0;
    end
  end

  assign res.valid       = out_valid;
  assign res.name_word   = out_word;
  assign res.word_bytes  = out_bytes;
  assign res.last_word   = out_last;
  assign res.malformed   = out_malformed;
  assign res.end_offset  = out_end;
  assign res.name_length = out_len;

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_malformed |-> out_last && (out_bytes == 4'd0))
    else $error("malformed result is not a lone empty last word");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> (out_bytes == 4'(WORD_BYTES)) && !out_malformed)
    else $error("non-final result word is not full");

  a_label_rem: assert property (@(posedge clk) disable iff (rst)
    state == W_LABEL |-> rem != 6'd0)
    else $error("label copy with nothing left to copy");

  a_name_cap: assert property (@(posedge clk) disable iff (rst)
    state != W_IDLE |-> (NLW+1)'(nlen) <= (NLW+1)'(MAX_NAME_BYTES))
    else $error("name length over limit");

  a_decode_start: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_kind == CMD_DECODE) |=> state == W_HEAD)
    else $error("decode transfer did not start the walk");

endmodule

// ===== design/dns_name_decompress.sv =====
// Top level of the DNS name decompressor: request queue, walker and result output.
// Load: the walker writes each byte into the packet store; a request queue of two entries decouples intake.
// Decode: the walker reads the packet bytes it walks through its single store read port, then for each
// 8-byte result word it reads the name buffer and then loads the output register.
// Reset clears the queue, walker state and output valid; packet store contents stay undefined.
module dns_name_decompress #(
  parameter int PACKET_BYTES   = dnd_pkg::PACKET_BYTES_DEF,
  parameter int MAX_NAME_BYTES = dnd_pkg::MAX_NAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dnd_req_if.sink   req,
  dnd_res_if.source res
);
  import dnd_pkg::*;

  localparam int AW  = $clog2(PACKET_BYTES);
  localparam int PLW = $clog2(PACKET_BYTES + 1);

  logic            cmd_valid;
  logic            cmd_ready;
  cmd_kind_t       cmd_kind;
  logic [AW-1:0]   cmd_addr;
  logic [7:0]      cmd_byte;
  logic [PLW-1:0]  cmd_plen;

  dnd_front #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_kind  (cmd_kind),
    .cmd_addr  (cmd_addr),
    .cmd_byte  (cmd_byte),
    .cmd_plen  (cmd_plen)
  );

  dnd_walk #(
    .PACKET_BYTES   (PACKET_BYTES),
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_kind  (cmd_kind),
    .cmd_addr  (cmd_addr),
    .cmd_byte  (cmd_byte),
    .cmd_plen  (cmd_plen),
    .res       (res)
  );

endmodule
